// ----- hw/rtl/urpc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character constants and helpers for the route path checker.
// No dependencies.
package urpc_pkg;

  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChQmark   = 8'h3F;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChUscore  = 8'h5F;
  localparam logic [7:0] ChTilde   = 8'h7E;
  localparam logic [7:0] ChDel     = 8'h7F;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNul     = 8'h00;

  localparam logic [1:0] EscNone = 2'd0;
  localparam logic [1:0] EscHigh = 2'd1;
  localparam logic [1:0] EscLow  = 2'd2;
  localparam logic [1:0] EscBad  = 2'd3;

  localparam logic [1:0] PosMax = 2'd2;
  localparam logic [1:0] SegMax = 2'd3;

  typedef struct packed {
    logic [1:0] position;
    logic [1:0] seg_len;
    logic       first_dot;
    logic       second_dot;
    logic [1:0] esc_phase;
    logic [3:0] esc_hi;
    logic       rejected;
  } state_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
        t = b - 8'h30;
      end else if (b >= 8'h61 && b <= 8'h66) begin
        t = b - 8'h57;
      end else if (b >= 8'h41 && b <= 8'h46) begin
        t = b - 8'h37;
      end else begin
        t = 8'd16;
      end
      return t[4:0];
    end
  endfunction

endpackage

// ----- hw/rtl/urpc_in_stage.sv -----
`timescale 1ns / 1ps
// Input register of the route path checker: holds one request until the
// step logic takes it. Depends on nothing but its ports.
module urpc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] path_byte_i,
  input  logic       is_end_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       end_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= path_byte_i;
      end_q  <= is_end_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign end_o   = end_q;

endmodule

// ----- hw/rtl/urpc_step.sv -----
`timescale 1ns / 1ps
// Next-state and verdict logic for one path byte or end marker.
// Depends on urpc_pkg.
module urpc_step import urpc_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output state_t     state_o,
  output logic       ok_o
);

  function automatic logic seg_is_dots(input state_t s);
    return (s.seg_len == 2'd1 && s.first_dot) ||
           (s.seg_len == 2'd2 && s.first_dot && s.second_dot);
  endfunction

  function automatic state_t count_byte(input state_t s, input logic [7:0] b);
    state_t r;
    begin
      r = s;
      if (s.seg_len == 2'd0) begin
        r.first_dot = (b == ChDot);
      end else if (s.seg_len == 2'd1) begin
        r.second_dot = (b == ChDot);
      end
      if (s.seg_len != SegMax) begin
        r.seg_len = s.seg_len + 2'd1;
      end
      return r;
    end
  endfunction

  logic [4:0] hv;
  logic [7:0] dec;
  logic       first;
  logic       plain;
  state_t     s;

  always_comb begin
    hv    = hex_value(byte_i);
    dec   = {state_i.esc_hi, hv[3:0]};
    first = (state_i.position == 2'd0);
    plain = (byte_i >= 8'h30 && byte_i <= 8'h39) ||
            (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
            (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
            (byte_i inside {ChDash, ChDot, ChUscore, ChTilde, ChPercent});
    ok_o  = !state_i.rejected && (state_i.position != 2'd0) &&
            (state_i.esc_phase == EscNone) && !seg_is_dots(state_i);
    s     = state_i;
    if (end_i) begin
      s = '0;
    end else begin
      if (state_i.position != PosMax) begin
        s.position = state_i.position + 2'd1;
      end
      if (!state_i.rejected) begin
        if (state_i.esc_phase != EscNone) begin
          s = count_byte(s, byte_i);
          if (hv[4]) begin
            s.rejected = 1'b1;
          end else if (state_i.esc_phase == EscHigh) begin
            s.esc_hi    = hv[3:0];
            s.esc_phase = EscLow;
          end else begin
            s.esc_phase = EscNone;
            s.esc_hi    = 4'd0;
            if (dec inside {ChDot, ChSlash, ChBslash, ChNul}) begin
              s.rejected = 1'b1;
            end
          end
        end else if (first) begin
          if (byte_i != ChSlash) begin
            s.rejected = 1'b1;
          end
        end else if (byte_i < ChSpace ||
                     (byte_i inside {ChDel, ChBslash, ChQmark, ChHash})) begin
          s.rejected = 1'b1;
        end else if (byte_i == ChSlash) begin
          if (state_i.seg_len == 2'd0 || seg_is_dots(state_i)) begin
            s.rejected = 1'b1;
          end else begin
            s.seg_len    = 2'd0;
            s.first_dot  = 1'b0;
            s.second_dot = 1'b0;
          end
        end else if (!plain) begin
          s.rejected = 1'b1;
        end else begin
          s = count_byte(s, byte_i);
          if (byte_i == ChPercent) begin
            s.esc_phase = EscHigh;
          end
        end
      end
    end
    state_o = s;
  end

endmodule

// ----- hw/rtl/uri_route_path_checker.sv -----
`timescale 1ns / 1ps
// Top level of the route path checker: input register, step logic, path
// state and result register. Depends on urpc_pkg, urpc_in_stage, urpc_step.
//
//   channel | signals                               | direction
//   in      | in_valid_i/in_ready_o, path_byte_i, is_end_i | byte or end in
//   out     | out_valid_o/out_ready_i, path_ok_o     | verdict per path
//
// One request per cycle unless an end request waits on a full result register;
// an accepted end request passes the input register, then the result register.
// The state update in urpc_step is combinational.
// Reset clears the path state and both valid flags; no clearing pass.
// An end request waits in the input register while the result register is
// full and not taken; byte requests never wait on the output side.
module uri_route_path_checker import urpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] path_byte_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       path_ok_o
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;
  logic       s1_take;
  logic       out_free;
  state_t     state_q, state_d;
  logic       ok;
  logic       out_valid_q, out_valid_d;
  logic       ok_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_take  = s1_valid && (!s1_end || out_free);

  urpc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .path_byte_i(path_byte_i),
    .is_end_i   (is_end_i),
    .take_i     (s1_take),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte),
    .end_o      (s1_end)
  );

  urpc_step u_step (
    .state_i(state_q),
    .byte_i (s1_byte),
    .end_i  (s1_end),
    .state_o(state_d),
    .ok_o   (ok)
  );

  assign out_valid_d = (s1_take && s1_end) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_take) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && s1_end) begin
      ok_q <= ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_ok_o   = ok_q;

  a_verdict_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_take && s1_end))
    else $error("verdict without end request");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && s1_end) |=> (state_q == '0))
    else $error("path state not cleared after end");

  a_no_bad_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.esc_phase != EscBad)
    else $error("escape phase reached unused code");

  a_stall_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid && s1_end && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked end request");

endmodule

// ----- tb/tb_uri_route_path_checker.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for uri_route_path_checker: directed table, then random paths,
// scored against an in-bench predictor of the path state. Depends on urpc_pkg and the RTL.
module tb_uri_route_path_checker;
  import urpc_pkg::*;

  localparam int NumDirRows  = 25;
  localparam int RandItems   = 1700;
  localparam int HoldCycles  = 300;
  localparam int TimeoutNs   = 5_000_000;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    logic       ok;
  } dir_row_t;

  // byte, end, verdict typed in, typed verdict
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'hFF,     1'b1, 1'b1, 1'b0},  // empty path
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{8'h00,     1'b1, 1'b1, 1'b1},  // root only
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{ChSlash,   1'b1, 1'b1, 1'b0},  // leading double slash
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{ChDot,     1'b0, 1'b0, 1'b0},
    '{8'h80,     1'b1, 1'b1, 1'b0},  // final dot segment
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{ChPercent, 1'b0, 1'b0, 1'b0},
    '{8'h34,     1'b0, 1'b0, 1'b0},
    '{8'h31,     1'b0, 1'b0, 1'b0},
    '{8'h7F,     1'b1, 1'b0, 1'b0},  // escape decoding to a letter
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{ChPercent, 1'b0, 1'b0, 1'b0},
    '{8'h32,     1'b0, 1'b0, 1'b0},
    '{8'h55,     1'b1, 1'b1, 1'b0},  // end inside an escape
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{8'hFF,     1'b0, 1'b0, 1'b0},
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{8'hAA,     1'b1, 1'b1, 1'b0},  // high byte, later bytes ignored
    '{ChSlash,   1'b0, 1'b0, 1'b0},
    '{ChNul,     1'b0, 1'b0, 1'b0},
    '{8'h01,     1'b1, 1'b1, 1'b0}   // control byte
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] path_byte   = 8'h00;
  logic       is_end      = 1'b0;
  logic       out_ready   = 1'b0;
  logic       in_typed    = 1'b0;
  logic       in_typed_ok = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       path_ok_o;

  state_t     path_state  = '0;
  logic       verdicts [$];
  logic       predicted_ok;
  logic       hold_req    = 1'b0;
  int         err_count   = 0;
  int         sent_items  = 0;
  int         burst_left  = 0;
  int         paths_ok    = 0;
  int         paths_bad   = 0;
  int         holds_done  = 0;
  int         rx_mode     = 0;
  int         rx_left     = 0;
  int         rx_tick     = 0;

  uri_route_path_checker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .path_byte_i (path_byte),
    .is_end_i    (is_end),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .path_ok_o   (path_ok_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------- predictor ----------------

  function automatic logic seg_is_dots();
    return (path_state.seg_len == 2'd1 && path_state.first_dot) ||
           (path_state.seg_len == 2'd2 && path_state.first_dot && path_state.second_dot);
  endfunction

  task automatic track_seg_byte(input logic [7:0] b);
    if (path_state.seg_len == 2'd0) begin
      path_state.first_dot = (b == ChDot);
    end else if (path_state.seg_len == 2'd1) begin
      path_state.second_dot = (b == ChDot);
    end
    if (path_state.seg_len < SegMax) path_state.seg_len = path_state.seg_len + 2'd1;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic       first;
    logic [4:0] hv;
    logic [7:0] dec;
    logic       plain;
    first = (path_state.position == 2'd0);
    if (path_state.position < PosMax) path_state.position = path_state.position + 2'd1;
    if (path_state.rejected) return;
    if (path_state.esc_phase != EscNone) begin
      hv = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) hv = 5'(b - 8'h30);
      else if (b >= 8'h61 && b <= 8'h66) hv = 5'(b - 8'h57);
      else if (b >= 8'h41 && b <= 8'h46) hv = 5'(b - 8'h37);
      track_seg_byte(b);
      if (hv[4]) begin
        path_state.rejected = 1'b1;
      end else if (path_state.esc_phase == EscHigh) begin
        path_state.esc_hi    = hv[3:0];
        path_state.esc_phase = EscLow;
      end else begin
        dec = {path_state.esc_hi, hv[3:0]};
        path_state.esc_phase = EscNone;
        path_state.esc_hi    = 4'd0;
        if (dec == ChDot || dec == ChSlash || dec == ChBslash || dec == ChNul) begin
          path_state.rejected = 1'b1;
        end
      end
      return;
    end
    if (first) begin
      if (b != ChSlash) path_state.rejected = 1'b1;
      return;
    end
    if (b < ChSpace || b == ChDel || b == ChBslash || b == ChQmark || b == ChHash) begin
      path_state.rejected = 1'b1;
      return;
    end
    if (b == ChSlash) begin
      if (path_state.seg_len == 2'd0 || seg_is_dots()) begin
        path_state.rejected = 1'b1;
      end else begin
        path_state.seg_len    = 2'd0;
        path_state.first_dot  = 1'b0;
        path_state.second_dot = 1'b0;
      end
      return;
    end
    plain = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A) || b == ChDash || b == ChDot ||
            b == ChUscore || b == ChTilde || b == ChPercent;
    if (!plain) begin
      path_state.rejected = 1'b1;
      return;
    end
    track_seg_byte(b);
    if (b == ChPercent) path_state.esc_phase = EscHigh;
  endtask

  task automatic predict_end(output logic ok);
    ok = !path_state.rejected && path_state.position != 2'd0 &&
         path_state.esc_phase == EscNone && !seg_is_dots();
    path_state = '0;
  endtask

  // ---------------- scoreboard ----------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (verdicts.size() == 0) begin
          $error("path_ok: unexpected verdict %0b with none pending", path_ok_o);
          err_count++;
        end else begin
          if (path_ok_o !== verdicts[0]) begin
            $error("path_ok: expected %0b, actual %0b", verdicts[0], path_ok_o);
            err_count++;
          end
          if (verdicts[0]) paths_ok++;
          else paths_bad++;
          void'(verdicts.pop_front());
        end
      end
      if (in_valid && in_ready_o) begin
        if (is_end) begin
          predict_end(predicted_ok);
          verdicts.push_back(in_typed ? in_typed_ok : predicted_ok);
        end else begin
          predict_byte(path_byte);
        end
      end
    end
  end

  // ---------------- receiver ----------------

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && holds_done == 0) begin
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        holds_done++;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  // ---------------- sender ----------------

  task automatic send_item(input logic [7:0] b, input logic e,
                           input logic typed, input logic typed_ok);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid    <= 1'b1;
    path_byte   <= b;
    is_end      <= e;
    in_typed    <= typed;
    in_typed_ok <= typed_ok;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
  endtask

  task automatic drain_wait();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_plain();
    int r;
    r = $urandom_range(0, 65);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 36) return 8'(8'h41 + r - 10);
    if (r < 62) return 8'(8'h61 + r - 36);
    case (r)
      62: return ChDash;
      63: return ChDot;
      64: return ChUscore;
      default: return ChTilde;
    endcase
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 16) return 8'(8'h61 + r - 10);
    return 8'(8'h41 + r - 16);
  endfunction

  function automatic logic [7:0] pick_bad();
    case ($urandom_range(0, 9))
      0: return ChNul;
      1: return 8'($urandom_range(1, 31));
      2: return ChDel;
      3: return ChBslash;
      4: return ChQmark;
      5: return ChHash;
      6: return ChSpace;
      7: return 8'($urandom_range(128, 255));
      8: return 8'h21;
      default: return 8'h3A;
    endcase
  endfunction

  task automatic random_path();
    int kind;
    int nseg;
    int seg;
    int len;
    int i;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      len = $urandom_range(0, 8);
      for (i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    end else begin
      if (kind < 11) send_item(($urandom_range(0, 1) == 0) ? pick_plain() : pick_bad(),
                               1'b0, 1'b0, 1'b0);
      else send_item(ChSlash, 1'b0, 1'b0, 1'b0);
      if (kind >= 11 && kind < 14) send_item(ChSlash, 1'b0, 1'b0, 1'b0);
      nseg = $urandom_range(0, 4);
      for (seg = 0; seg < nseg; seg++) begin
        if (seg != 0) send_item(ChSlash, 1'b0, 1'b0, 1'b0);
        case ($urandom_range(0, 19))
          0: ;
          1: send_item(ChDot, 1'b0, 1'b0, 1'b0);
          2, 3: begin
            len = $urandom_range(2, 3);
            for (i = 0; i < len; i++) send_item(ChDot, 1'b0, 1'b0, 1'b0);
          end
          4, 5, 6: begin
            send_item(ChPercent, 1'b0, 1'b0, 1'b0);
            if ($urandom_range(0, 2) == 0) begin
              // escapes that decode to a forbidden byte
              case ($urandom_range(0, 3))
                0: begin
                  send_item(8'h32, 1'b0, 1'b0, 1'b0);
                  send_item(($urandom_range(0, 1) == 0) ? 8'h65 : 8'h45, 1'b0, 1'b0, 1'b0);
                end
                1: begin
                  send_item(8'h32, 1'b0, 1'b0, 1'b0);
                  send_item(($urandom_range(0, 1) == 0) ? 8'h66 : 8'h46, 1'b0, 1'b0, 1'b0);
                end
                2: begin
                  send_item(8'h35, 1'b0, 1'b0, 1'b0);
                  send_item(($urandom_range(0, 1) == 0) ? 8'h63 : 8'h43, 1'b0, 1'b0, 1'b0);
                end
                default: begin
                  send_item(8'h30, 1'b0, 1'b0, 1'b0);
                  send_item(8'h30, 1'b0, 1'b0, 1'b0);
                end
              endcase
            end else begin
              send_item(pick_hex(), 1'b0, 1'b0, 1'b0);
              send_item(pick_hex(), 1'b0, 1'b0, 1'b0);
            end
            if ($urandom_range(0, 1) == 0) send_item(pick_plain(), 1'b0, 1'b0, 1'b0);
          end
          7: begin
            // escape that is often broken: short, or with a random byte as a digit
            send_item(ChPercent, 1'b0, 1'b0, 1'b0);
            if ($urandom_range(0, 1) == 0) send_item(pick_hex(), 1'b0, 1'b0, 1'b0);
            if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(0, 255)),
                                                     1'b0, 1'b0, 1'b0);
          end
          default: begin
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++) begin
              if ($urandom_range(0, 29) == 0) send_item(pick_bad(), 1'b0, 1'b0, 1'b0);
              else send_item(pick_plain(), 1'b0, 1'b0, 1'b0);
            end
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0) send_item(ChSlash, 1'b0, 1'b0, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
  endtask

  initial begin
    int row;
    int i;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    for (row = 0; row < NumDirRows; row++) begin
      send_item(DirRows[row].b, DirRows[row].e, DirRows[row].typed, DirRows[row].ok);
    end
    drain_wait();

    while (sent_items < RandItems) begin
      if (holds_done == 0 && sent_items > 600) begin
        // output held off while short paths keep coming
        hold_req = 1'b1;
        for (i = 0; i < 30; i++) begin
          send_item(ChSlash, 1'b0, 1'b0, 1'b0);
          send_item(pick_plain(), 1'b0, 1'b0, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
        end
        drain_wait();
        hold_req = 1'b0;
      end
      random_path();
    end

    drain_wait();
    repeat (10) @(posedge clk_i);
    if (verdicts.size() != 0) begin
      $error("path_ok: %0d verdicts never arrived", verdicts.size());
    end
    $display("Covered %0d requests and %0d paths (%0d accepted, %0d rejected),",
             sent_items, paths_ok + paths_bad, paths_ok, paths_bad);
    $display("with %0d long output hold-offs and random stalls on both sides.", holds_done);
    if (err_count == 0 && verdicts.size() == 0) begin
      $display("tb_uri_route_path_checker: clean");
    end else begin
      $display("tb_uri_route_path_checker: errors");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("tb_uri_route_path_checker: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/urpc_pkg.sv
hw/rtl/urpc_in_stage.sv
hw/rtl/urpc_step.sv
hw/rtl/uri_route_path_checker.sv
tb/tb_uri_route_path_checker.sv
